>>> hdl/gtg_pkg.sv
package gtg_pkg;

   localparam int MAX_STAGES = 24;
   localparam int GUARD_BITS = 12;
   localparam int ANG_FRAC   = 30;

   localparam int POS_W  = 15;
   localparam int DIFF_W = 16;
   localparam int XY_W   = 31;
   localparam int Z_W    = 35;
   localparam int BEAR_W = 17;
   localparam int ERR_W  = 18;

   localparam logic signed [Z_W-1:0]   PI_Q30       = 35'sd3373259426;
   localparam logic [29:0]             INV_GAIN_Q30 = 30'd652032874;
   localparam logic signed [ERR_W-1:0] PI_Q12       = 18'sd12868;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q12   = 18'sd25736;

   localparam logic [11:0] LINEAR_GAIN_RESET  = 12'd512;
   localparam logic [11:0] ANGULAR_GAIN_RESET = 12'd512;
   localparam logic [15:0] DIST_TOL_RESET     = 16'd102;
   localparam logic [13:0] HEAD_TOL_RESET     = 14'd410;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type REG_LINEAR_GAIN  = 2'd0;
   localparam csr_index_type REG_ANGULAR_GAIN = 2'd1;
   localparam csr_index_type REG_DIST_TOL     = 2'd2;
   localparam csr_index_type REG_HEAD_TOL     = 2'd3;

   typedef struct packed {
      logic [11:0] linear_gain;
      logic [11:0] angular_gain;
      logic [15:0] distance_tolerance;
      logic [13:0] heading_tolerance;
   } cfg_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [POS_W-1:0]  heading;
      logic                     zero;
   } cordic_in_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic signed [POS_W-1:0] heading;
      logic                    zero;
   } vec_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [Z_W-1:0]   z;
      logic signed [POS_W-1:0] heading;
      logic                    zero;
   } cordic_out_type;

   typedef struct packed {
      logic [15:0]        linear_speed;
      logic signed [15:0] angular_speed;
      logic               goal_reached;
   } rsp_type;

   // atan(2^-i) in q5.30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0:       v = 35'sd843314856;
         1:       v = 35'sd497837829;
         2:       v = 35'sd263043836;
         3:       v = 35'sd133525158;
         4:       v = 35'sd67021686;
         5:       v = 35'sd33543515;
         6:       v = 35'sd16775850;
         7:       v = 35'sd8388437;
         8:       v = 35'sd4194282;
         9:       v = 35'sd2097149;
         10:      v = 35'sd1048575;
         11:      v = 35'sd524287;
         12:      v = 35'sd262143;
         13:      v = 35'sd131071;
         14:      v = 35'sd65535;
         15:      v = 35'sd32767;
         16:      v = 35'sd16383;
         17:      v = 35'sd8191;
         18:      v = 35'sd4095;
         19:      v = 35'sd2047;
         20:      v = 35'sd1023;
         21:      v = 35'sd511;
         22:      v = 35'sd255;
         23:      v = 35'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/gtg_cordic.sv
module gtg_cordic #(
   parameter int STAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gtg_pkg::cordic_in_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gtg_pkg::cordic_out_type out_data
);

   gtg_pkg::vec_type   vec_ff [0:STAGES];
   gtg_pkg::vec_type   pre_in;
   logic [STAGES:0]    valid_ff;
   logic [STAGES+1:0]  ready;

   assign ready[STAGES+1] = out_ready;
   assign in_ready        = ready[0];

   // pre-rotation by pi into the right half plane
   always_comb begin
      logic signed [gtg_pkg::XY_W-1:0] px;
      logic signed [gtg_pkg::XY_W-1:0] py;
      px = {{(gtg_pkg::XY_W-gtg_pkg::DIFF_W-gtg_pkg::GUARD_BITS){in_data.dx[gtg_pkg::DIFF_W-1]}},
            in_data.dx, gtg_pkg::GUARD_BITS'(0)};
      py = {{(gtg_pkg::XY_W-gtg_pkg::DIFF_W-gtg_pkg::GUARD_BITS){in_data.dy[gtg_pkg::DIFF_W-1]}},
            in_data.dy, gtg_pkg::GUARD_BITS'(0)};
      pre_in.heading = in_data.heading;
      pre_in.zero    = in_data.zero;
      if (in_data.dx[gtg_pkg::DIFF_W-1]) begin
         pre_in.x = -px;
         pre_in.y = -py;
         pre_in.z = in_data.dy[gtg_pkg::DIFF_W-1] ? -gtg_pkg::PI_Q30 : gtg_pkg::PI_Q30;
      end else begin
         pre_in.x = px;
         pre_in.y = py;
         pre_in.z = '0;
      end
   end

   assign ready[0] = ~valid_ff[0] | ready[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         valid_ff[0] <= in_valid;
      end
      if (ready[0] && in_valid) begin
         vec_ff[0] <= pre_in;
      end
   end

   for (genvar k = 1; k <= STAGES; k++) begin : g_stage
      localparam int I = k - 1;
      gtg_pkg::vec_type nxt_in;

      always_comb begin
         logic signed [gtg_pkg::XY_W-1:0] xs;
         logic signed [gtg_pkg::XY_W-1:0] ys;
         xs = vec_ff[k-1].x >>> I;
         ys = vec_ff[k-1].y >>> I;
         nxt_in = vec_ff[k-1];
         if (!vec_ff[k-1].y[gtg_pkg::XY_W-1]) begin
            nxt_in.x = vec_ff[k-1].x + ys;
            nxt_in.y = vec_ff[k-1].y - xs;
            nxt_in.z = vec_ff[k-1].z + gtg_pkg::atan_q30(I);
         end else begin
            nxt_in.x = vec_ff[k-1].x - ys;
            nxt_in.y = vec_ff[k-1].y + xs;
            nxt_in.z = vec_ff[k-1].z - gtg_pkg::atan_q30(I);
         end
      end

      assign ready[k] = ~valid_ff[k] | ready[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (ready[k] && valid_ff[k-1]) begin
            vec_ff[k] <= nxt_in;
         end
      end
   end

   assign out_valid        = valid_ff[STAGES];
   assign out_data.x       = vec_ff[STAGES].x;
   assign out_data.z       = vec_ff[STAGES].z;
   assign out_data.heading = vec_ff[STAGES].heading;
   assign out_data.zero    = vec_ff[STAGES].zero;

endmodule

>>> hdl/gtg_steer.sv
module gtg_steer (
   input  logic                    clock,
   input  logic                    reset,
   input  gtg_pkg::cfg_type        cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  gtg_pkg::cordic_out_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output gtg_pkg::rsp_type        out_data
);

   // stage a: distance scaling product, bearing rounding
   logic                              a_valid_ff;
   logic [59:0]                       a_prod_ff, a_prod_in;
   logic signed [gtg_pkg::BEAR_W-1:0] a_bear_ff, a_bear_in;
   logic signed [gtg_pkg::POS_W-1:0]  a_head_ff;
   // stage b: distance, wrapped heading error
   logic                              b_valid_ff;
   logic [15:0]                       b_dist_ff, b_dist_in;
   logic signed [gtg_pkg::ERR_W-1:0]  b_err_ff, b_err_in;
   // stage c: tolerance check, gain products
   logic                              c_valid_ff;
   logic                              c_reached_ff, c_reached_in;
   logic [27:0]                       c_lin_ff, c_lin_in;
   logic signed [30:0]                c_ang_ff, c_ang_in;
   // stage d: output register
   logic                              d_valid_ff;
   gtg_pkg::rsp_type                  d_data_ff, d_data_in;

   logic a_ready, b_ready, c_ready, d_ready;

   assign d_ready  = ~d_valid_ff | out_ready;
   assign c_ready  = ~c_valid_ff | d_ready;
   assign b_ready  = ~b_valid_ff | c_ready;
   assign a_ready  = ~a_valid_ff | b_ready;
   assign in_ready = a_ready;

   always_comb begin
      logic [29:0]                    xc;
      logic signed [gtg_pkg::Z_W-1:0] zr;
      xc = in_data.x[gtg_pkg::XY_W-1] ? '0 : in_data.x[29:0];
      a_prod_in = 60'(xc) * 60'(gtg_pkg::INV_GAIN_Q30);
      zr = in_data.z + (gtg_pkg::Z_W'(1) <<< (gtg_pkg::ANG_FRAC - 13));
      a_bear_in = in_data.zero ? '0 : zr[gtg_pkg::Z_W-1:gtg_pkg::ANG_FRAC-12];
   end

   always_comb begin
      logic [60:0]                      sum;
      logic [18:0]                      d19;
      logic signed [gtg_pkg::ERR_W-1:0] e0;
      logic signed [gtg_pkg::ERR_W-1:0] e1;
      sum = {1'b0, a_prod_ff} + (61'd1 << (gtg_pkg::ANG_FRAC + gtg_pkg::GUARD_BITS - 1));
      d19 = sum[60:42];
      b_dist_in = (d19 > 19'd65535) ? 16'hffff : d19[15:0];
      e0 = gtg_pkg::ERR_W'(a_bear_ff) - gtg_pkg::ERR_W'(a_head_ff);
      e1 = (e0 > gtg_pkg::PI_Q12) ? e0 - gtg_pkg::TWO_PI_Q12 : e0;
      b_err_in = (e1 < -gtg_pkg::PI_Q12) ? e1 + gtg_pkg::TWO_PI_Q12 : e1;
   end

   always_comb begin
      logic [gtg_pkg::ERR_W-2:0]        aerr;
      logic signed [gtg_pkg::ERR_W-1:0] neg;
      neg  = -b_err_ff;
      aerr = b_err_ff[gtg_pkg::ERR_W-1] ? neg[gtg_pkg::ERR_W-2:0]
                                        : b_err_ff[gtg_pkg::ERR_W-2:0];
      c_reached_in = !((b_dist_ff > cfg.distance_tolerance) ||
                       (aerr > (gtg_pkg::ERR_W-1)'(cfg.heading_tolerance)));
      c_lin_in = 28'(cfg.linear_gain) * 28'(b_dist_ff);
      c_ang_in = $signed({1'b0, cfg.angular_gain}) * b_err_ff;
   end

   always_comb begin
      logic [28:0]        lsum;
      logic signed [30:0] asum;
      logic [20:0]        l21;
      logic signed [22:0] a23;
      lsum = {1'b0, c_lin_ff} + 29'd128;
      asum = c_ang_ff + 31'sd128;
      l21  = lsum[28:8];
      a23  = asum[30:8];
      d_data_in.goal_reached = c_reached_ff;
      if (c_reached_ff) begin
         d_data_in.linear_speed  = '0;
         d_data_in.angular_speed = '0;
      end else begin
         d_data_in.linear_speed = (l21 > 21'd65535) ? 16'hffff : l21[15:0];
         if (a23 > 23'sd32767) begin
            d_data_in.angular_speed = 16'sh7fff;
         end else if (a23 < -23'sd32768) begin
            d_data_in.angular_speed = 16'sh8000;
         end else begin
            d_data_in.angular_speed = a23[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
         if (d_ready) begin
            d_valid_ff <= c_valid_ff;
         end
      end
      if (a_ready && in_valid) begin
         a_prod_ff <= a_prod_in;
         a_bear_ff <= a_bear_in;
         a_head_ff <= in_data.heading;
      end
      if (b_ready && a_valid_ff) begin
         b_dist_ff <= b_dist_in;
         b_err_ff  <= b_err_in;
      end
      if (c_ready && b_valid_ff) begin
         c_reached_ff <= c_reached_in;
         c_lin_ff     <= c_lin_in;
         c_ang_ff     <= c_ang_in;
      end
      if (d_ready && c_valid_ff) begin
         d_data_ff <= d_data_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

>>> hdl/go_to_goal_p_controller_unit.sv
// channel   direction  handshake                fields (lsb first)
// req       in         req_tvalid/req_tready    cur_x, cur_y, cur_heading, goal_x, goal_y
// rsp       out        rsp_tvalid/rsp_tready    tdata: linear_speed, angular_speed; tuser: goal_reached
// csr       in         csr_valid/csr_ready      csr_index, csr_data
//
// one transaction per cycle sustained while rsp_tready stays high; stages in order are the
// input register, pre-rotation, one register per cordic iteration, four output stages
// synchronous active-high reset clears all valid bits and loads register defaults
// every stage holds its data while the stage after it is full and stalled;
// empty stages fill up behind a stalled result, and csr writes are always taken
module go_to_goal_p_controller_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // cur_x, cur_y, cur_heading, goal_x, goal_y, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // linear_speed, angular_speed
   output logic        rsp_tuser,   // goal_reached
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int STAGE_COUNT = (CORDIC_STAGES > gtg_pkg::MAX_STAGES) ?
                                gtg_pkg::MAX_STAGES : CORDIC_STAGES;

   gtg_pkg::cfg_type        cfg_ff;
   gtg_pkg::cordic_in_type  in_ff, in_in;
   logic                    in_valid_ff;
   logic                    cordic_ready;
   logic                    cordic_valid;
   gtg_pkg::cordic_out_type cordic_data;
   gtg_pkg::rsp_type        rsp_data;
   logic                    steer_ready;

   logic signed [gtg_pkg::POS_W-1:0] cur_x, cur_y, cur_heading, goal_x, goal_y;

   assign cur_x       = req_tdata[14:0];
   assign cur_y       = req_tdata[29:15];
   assign cur_heading = req_tdata[44:30];
   assign goal_x      = req_tdata[59:45];
   assign goal_y      = req_tdata[74:60];

   always_comb begin
      in_in.dx      = gtg_pkg::DIFF_W'(goal_x) - gtg_pkg::DIFF_W'(cur_x);
      in_in.dy      = gtg_pkg::DIFF_W'(goal_y) - gtg_pkg::DIFF_W'(cur_y);
      in_in.heading = cur_heading;
      in_in.zero    = (in_in.dx == '0) && (in_in.dy == '0);
   end

   assign req_tready = ~in_valid_ff | cordic_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_ff <= in_in;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_gain        <= gtg_pkg::LINEAR_GAIN_RESET;
         cfg_ff.angular_gain       <= gtg_pkg::ANGULAR_GAIN_RESET;
         cfg_ff.distance_tolerance <= gtg_pkg::DIST_TOL_RESET;
         cfg_ff.heading_tolerance  <= gtg_pkg::HEAD_TOL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            gtg_pkg::REG_LINEAR_GAIN:  cfg_ff.linear_gain        <= csr_data[11:0];
            gtg_pkg::REG_ANGULAR_GAIN: cfg_ff.angular_gain       <= csr_data[11:0];
            gtg_pkg::REG_DIST_TOL:     cfg_ff.distance_tolerance <= csr_data;
            gtg_pkg::REG_HEAD_TOL:     cfg_ff.heading_tolerance  <= csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   gtg_cordic #(
      .STAGES(STAGE_COUNT)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (cordic_ready),
      .in_data   (in_ff),
      .out_valid (cordic_valid),
      .out_ready (steer_ready),
      .out_data  (cordic_data)
   );

   gtg_steer u_steer (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cordic_valid),
      .in_ready  (steer_ready),
      .in_data   (cordic_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {rsp_data.angular_speed, rsp_data.linear_speed};
   assign rsp_tuser = rsp_data.goal_reached;

   a_reached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("goal reached with nonzero speed");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

>>> bench/tb_go_to_goal_p_controller_unit.sv
module tb_go_to_goal_p_controller_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES       = 16;
   localparam int LATENCY      = STAGES + 6;
   localparam int DRAIN_CYCLES = 2 * LATENCY + 10;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 300;

   localparam longint HALF_TURN_Q30    = 64'sd3373259426;
   localparam longint HALF_TURN        = 12868;
   localparam longint FULL_TURN        = 25736;
   localparam longint CORDIC_SCALE_Q30 = 652032874;
   localparam longint DIST_ROUND       = 64'sd2199023255552;
   localparam longint BEARING_ROUND    = 131072;

   localparam logic signed [14:0] POS_MIN = 15'h4000;
   localparam logic signed [14:0] POS_MAX = 15'h3FFF;

   typedef struct {
      logic signed [14:0] cur_x;
      logic signed [14:0] cur_y;
      logic signed [14:0] cur_heading;
      logic signed [14:0] goal_x;
      logic signed [14:0] goal_y;
   } pose_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // cur_x, cur_y, cur_heading, goal_x, goal_y, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // linear_speed, angular_speed
   logic        rsp_tuser;        // goal_reached
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   longint angle_table [0:23] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   longint lin_gain  = 512;
   longint ang_gain  = 512;
   longint dist_tol  = 102;
   longint head_tol  = 410;

   pose_item_type             pose_backlog [$];
   gtg_pkg::rsp_type          expected_cmds [$];
   pose_item_type             offered_pose;
   gtg_pkg::rsp_type          want;

   int  items_queued   = 0;
   int  items_accepted = 0;
   int  results_seen   = 0;
   int  goals_reached  = 0;
   int  mismatches     = 0;
   int  settings_used  = 1;
   int  req_gap        = 0;
   int  rsp_stall      = 0;
   int  hold_left      = 0;
   int  holds_done     = 0;
   int  cycle_count    = 0;
   bit  quiet          = 1'b0;

   go_to_goal_p_controller_unit #(
      .CORDIC_STAGES(STAGES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // distance and bearing to the goal by cordic vectoring
   function automatic void goal_polar(input longint dx, input longint dy,
                                      output longint range_q10, output longint bearing);
      longint x, y, z, xs, ys;
      int i;
      range_q10 = 0;
      bearing = 0;
      if (dx != 0 || dy != 0) begin
         x = dx <<< 12;
         y = dy <<< 12;
         z = 0;
         if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
         end
         for (i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + angle_table[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - angle_table[i];
            end
         end
         if (x < 0) x = 0;
         range_q10 = (x * CORDIC_SCALE_Q30 + DIST_ROUND) >>> 42;
         if (range_q10 > 65535) range_q10 = 65535;
         bearing = (z + BEARING_ROUND) >>> 18;
      end
   endfunction

   function automatic longint heading_error(longint bearing, longint heading);
      longint err;
      err = bearing - heading;
      if (err > HALF_TURN) err = err - FULL_TURN;
      if (err < -HALF_TURN) err = err + FULL_TURN;
      return err;
   endfunction

   function automatic gtg_pkg::rsp_type predict_command(pose_item_type p);
      longint range_q10, bearing, err, aerr, lin, ang;
      gtg_pkg::rsp_type r;
      goal_polar(longint'(p.goal_x) - longint'(p.cur_x),
                 longint'(p.goal_y) - longint'(p.cur_y), range_q10, bearing);
      err = heading_error(bearing, longint'(p.cur_heading));
      aerr = (err < 0) ? -err : err;
      r = '0;
      if (range_q10 > dist_tol || aerr > head_tol) begin
         lin = (lin_gain * range_q10 + 128) >>> 8;
         if (lin > 65535) lin = 65535;
         ang = (ang_gain * err + 128) >>> 8;
         if (ang > 32767) ang = 32767;
         if (ang < -32768) ang = -32768;
         r.linear_speed  = lin[15:0];
         r.angular_speed = ang[15:0];
      end else begin
         r.goal_reached = 1'b1;
      end
      return r;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [14:0] clamp_pos(int v);
      if (v > 16383) v = 16383;
      if (v < -16384) v = -16384;
      return v[14:0];
   endfunction

   function automatic logic signed [14:0] extreme_pos();
      int pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) return POS_MIN;
      if (pick == 1) return POS_MAX;
      return 15'($urandom);
   endfunction

   function automatic pose_item_type make_pose(int cx, int cy, int ch, int gx, int gy);
      pose_item_type p;
      p.cur_x       = cx[14:0];
      p.cur_y       = cy[14:0];
      p.cur_heading = ch[14:0];
      p.goal_x      = gx[14:0];
      p.goal_y      = gy[14:0];
      return p;
   endfunction

   function automatic pose_item_type random_pose();
      pose_item_type p;
      int kind;
      longint d, b;
      kind = $urandom_range(0, 99);
      p.cur_x       = 15'($urandom);
      p.cur_y       = 15'($urandom);
      p.goal_x      = 15'($urandom);
      p.goal_y      = 15'($urandom);
      p.cur_heading = 15'($urandom_range(0, 25736) - 12868);
      if (kind < 30) begin
         // goal close by, heading roughly aimed at it
         p.goal_x = clamp_pos(p.cur_x + int'($urandom_range(0, 240)) - 120);
         p.goal_y = clamp_pos(p.cur_y + int'($urandom_range(0, 240)) - 120);
         goal_polar(longint'(p.goal_x) - longint'(p.cur_x),
                    longint'(p.goal_y) - longint'(p.cur_y), d, b);
         p.cur_heading = clamp_pos(int'(b) + int'($urandom_range(0, 1000)) - 500);
      end else if (kind < 45) begin
         p.cur_heading = 15'($urandom);
      end else if (kind < 53) begin
         p.goal_x = p.cur_x;
         p.goal_y = p.cur_y;
         p.cur_heading = 15'($urandom_range(0, 1200) - 600);
      end else if (kind < 63) begin
         p.cur_x  = extreme_pos();
         p.cur_y  = extreme_pos();
         p.goal_x = extreme_pos();
         p.goal_y = extreme_pos();
      end
      return p;
   endfunction

   task automatic queue_pose(pose_item_type p);
      pose_backlog.push_back(p);
      items_queued++;
   endtask

   task automatic queue_random(int count);
      int k;
      for (k = 0; k < count; k++) queue_pose(random_pose());
   endtask

   task automatic wait_idle();
      while (items_accepted != items_queued || expected_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(gtg_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         gtg_pkg::REG_LINEAR_GAIN:  lin_gain = value[11:0];
         gtg_pkg::REG_ANGULAR_GAIN: ang_gain = value[11:0];
         gtg_pkg::REG_DIST_TOL:     dist_tol = value[15:0];
         gtg_pkg::REG_HEAD_TOL:     head_tol = value[13:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int lg, int ag, int dt, int ht);
      wait_idle();
      write_reg(gtg_pkg::REG_LINEAR_GAIN, lg[15:0]);
      write_reg(gtg_pkg::REG_ANGULAR_GAIN, ag[15:0]);
      write_reg(gtg_pkg::REG_DIST_TOL, dt[15:0]);
      write_reg(gtg_pkg::REG_HEAD_TOL, ht[15:0]);
      settings_used++;
   endtask

   task automatic note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_cmds.push_back(predict_command(offered_pose));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pose_backlog.size() != 0) begin
               offered_pose = pose_backlog.pop_front();
               req_tdata <= {5'b0, offered_pose.goal_y, offered_pose.goal_x,
                             offered_pose.cur_heading, offered_pose.cur_y, offered_pose.cur_x};
               req_tvalid <= 1'b1;
               req_gap = quiet ? 0 : draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (rsp_tuser) goals_reached++;
            if (expected_cmds.size() == 0) begin
               note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_tdata[15:0] !== want.linear_speed ||
                   rsp_tdata[31:16] !== want.angular_speed ||
                   rsp_tuser !== want.goal_reached)
                  note_failure($sformatf(
                     "result %0d: want lin %0d ang %0d goal %0d, got lin %0d ang %0d goal %0d",
                     results_seen, want.linear_speed, $signed(want.angular_speed),
                     want.goal_reached, rsp_tdata[15:0], $signed(rsp_tdata[31:16]), rsp_tuser));
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15) rsp_stall = draw_gap();
         end
      end
   end

   // long receiver hold-off so the pipeline fills and backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && results_seen >= 250 * (holds_done + 1)) begin
         hold_left  <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_cmds.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      longint d, b, e;
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed poses under reset settings
      queue_pose(make_pose(0, 0, 0, 0, 0));
      queue_pose(make_pose(0, 0, 12868, 0, 0));
      queue_pose(make_pose(-16384, -16384, -16384, 16383, 16383));
      queue_pose(make_pose(16383, 16383, 16383, -16384, -16384));
      queue_pose(make_pose(100, 0, 12868, -100, 0));
      queue_pose(make_pose(100, 1, 12868, -100, 0));
      queue_pose(make_pose(0, 0, 0, 0, 500));
      queue_pose(make_pose(0, 0, 0, 0, -500));
      queue_pose(make_pose(500, 300, -12868, -500, 300));
      queue_pose(make_pose(-16384, 0, 0, 16383, 0));
      queue_pose(make_pose(0, 0, 0, 1, 0));
      queue_pose(make_pose(7, -3, 16383, 7, -3));
      queue_pose(make_pose(7, -3, -16384, 7, -3));
      queue_pose(make_pose(7, -3, 12869, 7, -3));
      queue_pose(make_pose(7, -3, -12869, 7, -3));
      goal_polar(50, 30, d, b);
      queue_pose(make_pose(-2000, 4000, int'(b), -1950, 4030));
      queue_random(100);

      // saturating gains, zero tolerances, no idling on either side
      set_config(4095, 4095, 0, 0);
      quiet = 1'b1;
      queue_random(100);

      // zero gains, widest tolerances
      set_config(0, 0, 65535, 12868);
      quiet = 1'b0;
      queue_random(80);

      // tolerances set exactly to the distance and error of one pose
      wait_idle();
      goal_polar(300, -150, d, b);
      e = heading_error(b, 0);
      set_config(512, 512, int'(d), int'((e < 0) ? -e : e));
      queue_pose(make_pose(1000, 2000, 0, 1300, 1850));
      queue_pose(make_pose(1000, 2000, 1, 1300, 1850));
      queue_pose(make_pose(1000, 2000, -1, 1300, 1850));
      queue_pose(make_pose(1000, 2000, 0, 1301, 1850));

      for (k = 0; k < 4; k++) begin
         set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                    (k == 2) ? $urandom_range(0, 65535) : $urandom_range(0, 600),
                    $urandom_range(0, 2000));
         queue_random(115);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d poses under %0d register settings, %0d results checked",
               items_accepted, settings_used, results_seen);
      $display("%0d results flagged goal reached, %0d failures", goals_reached, mismatches);
      if (mismatches == 0 && expected_cmds.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/gtg_pkg.sv
hdl/gtg_cordic.sv
hdl/gtg_steer.sv
hdl/go_to_goal_p_controller_unit.sv
bench/tb_go_to_goal_p_controller_unit.sv
